@@ sv/isrt_pkg.sv @@
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and constants for the insertion sorter
// Data width, default depth and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;  // place value into the ordered row
        logic   shift;   // move every entry down by one place (drain)
        value_t value;   // value being inserted
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/isrt_cell.sv @@
// ----------------------------------------------------------------------------
// isrt_cell: one place of the ordered row
// Holds one value; on insert it keeps, takes the new value or takes its left
// neighbor's value; on drain it takes its right neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire isrt_pkg::cell_ctrl_t ctrl,
    input  wire isrt_pkg::value_t     left_value,
    input  wire logic                 left_valid,
    input  wire logic                 left_gt,
    input  wire isrt_pkg::value_t     right_value,
    input  wire logic                 right_valid,
    output      isrt_pkg::value_t     value,
    output      logic                 valid,
    output      logic                 gt
);

    isrt_pkg::value_t value_reg;
    isrt_pkg::value_t value_next;
    logic             valid_reg;
    logic             valid_next;
    logic             take;

    // Strictly greater: equal entries stay put, so arrival order holds
    assign gt   = valid_reg && (value_reg > ctrl.value);
    assign take = gt || (!valid_reg && left_valid);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.insert && take)
        begin
            value_next = left_gt ? left_value : ctrl.value;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ sv/insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter: stable ascending sorter on a systolic insertion chain
// Flow: a request is placed in the row directly while a place is free; a set
// closed by last drains from the next cycle on, and each popped entry is on
// the ports in the cycle after, smallest first. Throughput: one request per
// cycle while loading, then busy while the set drains, paced by the single
// head output. The receiver cannot stall. Reset empties the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter
#(
    parameter int DEPTH = isrt_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic signed [isrt_pkg::VALUE_W-1:0] value,
    input  wire logic                         last,
    output      logic                         strobe,
    output      logic signed [isrt_pkg::VALUE_W-1:0] sorted_value,
    output      logic                         final_res,
    output      logic                         overflow
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Chain wiring: one slot per cell
    isrt_pkg::value_t     cell_value [DEPTH];
    logic                 cell_valid [DEPTH];
    logic                 cell_gt    [DEPTH];
    isrt_pkg::cell_ctrl_t ctrl;

    // Control state
    logic             drain_reg,   drain_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             dropped_reg, dropped_next;

    // Output register, parted from the chain so a new set may load while the
    // final result of the previous one is still on the ports
    logic             strobe_reg,  strobe_next;
    logic             final_reg,   final_next;
    logic             ovf_reg,     ovf_next;
    isrt_pkg::value_t out_reg,     out_next;

    logic accept;
    logic full;

    assign accept = start && !drain_reg;
    assign full   = (count_reg == CNT_W'(DEPTH));

    // Broadcast: insert only when a place is free, else drop the request
    always_comb
    begin
        ctrl.insert = accept && !full;
        ctrl.shift  = drain_reg;
        ctrl.value  = value;
    end

    // The row of cells; cell 0 holds the smallest entry
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        isrt_pkg::value_t lv;
        logic             lval;
        logic             lgt;
        isrt_pkg::value_t rv;
        logic             rval;

        if (i == 0)
        begin : g_head
            assign lv   = '0;
            assign lval = 1'b1;
            assign lgt  = 1'b0;
        end
        else
        begin : g_body
            assign lv   = cell_value[i-1];
            assign lval = cell_valid[i-1];
            assign lgt  = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rv   = '0;
            assign rval = 1'b0;
        end
        else
        begin : g_mid
            assign rv   = cell_value[i+1];
            assign rval = cell_valid[i+1];
        end

        isrt_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_valid  (lval),
            .left_gt     (lgt),
            .right_value (rv),
            .right_valid (rval),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        drain_next   = drain_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        strobe_next  = 1'b0;
        final_next   = final_reg;
        ovf_next     = ovf_reg;
        out_next     = out_reg;

        if (drain_reg)
        begin
            // Pop the head of the chain; the cells shift down together
            strobe_next = 1'b1;
            out_next    = cell_value[0];
            final_next  = (count_reg == CNT_W'(1));
            ovf_next    = dropped_reg;
            count_next  = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            // Close the set; at least one entry is held from here on
            if (last)
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Result payload: qualified by strobe, no reset needed
    always_ff @(posedge clk)
    begin
        final_reg <= final_next;
        ovf_reg   <= ovf_next;
        out_reg   <= out_next;
    end

    assign busy         = drain_reg;
    assign strobe       = strobe_reg;
    assign sorted_value = out_reg;
    assign final_res    = final_reg;
    assign overflow     = ovf_reg;

endmodule

`default_nettype wire
